FILE: src/shd_pkg.sv
package shd_pkg;

    localparam int MIX_W   = 8;
    localparam int CFG_W   = 17;
    localparam int IDX_W   = 16;
    localparam int MULT_W  = 16;
    localparam int PROD_W  = MIX_W + MULT_W;
    localparam int CNT_W   = $clog2(PROD_W);

    localparam logic [MULT_W-1:0] GOLDEN_MULT      = 16'd40503;
    localparam logic [CFG_W-1:0]  BUCKET_COUNT_RST = 17'd1024;

    typedef struct packed {
        logic start;
        logic ack;
    } t_mod_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_mod_stat;

endpackage

FILE: src/shd_mod_unit.sv
module shd_mod_unit #(
    parameter int BUCKET_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  shd_pkg::t_mod_ctl               i_ctl,
    input  logic [shd_pkg::MIX_W-1:0]       i_mix,
    input  logic [shd_pkg::CFG_W-1:0]       i_bucket_count,
    output shd_pkg::t_mod_stat              o_stat,
    output logic [BUCKET_BITS-1:0]          o_rem
);

    localparam int DW = BUCKET_BITS + 1;
    localparam int CW = (DW > shd_pkg::CFG_W) ? DW : shd_pkg::CFG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic [shd_pkg::MIX_W-1:0]      r_mix;
    logic [shd_pkg::PROD_W-1:0]     r_prod;
    logic [BUCKET_BITS-1:0]         r_rem;
    logic [DW-1:0]                  r_div;
    logic [shd_pkg::CNT_W-1:0]      r_cnt;

    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] cap;
    logic [CW-1:0] eff_div;
    logic [DW-1:0] trial;
    logic [DW-1:0] diff;

    assign cnt_ext = CW'(i_bucket_count);
    assign cap     = CW'(1) << BUCKET_BITS;

    always_comb begin
        priority if (cnt_ext == '0) begin
            eff_div = CW'(1);
        end else if (cnt_ext > cap) begin
            eff_div = cap;
        end else begin
            eff_div = cnt_ext;
        end
    end

    // one restoring step per cycle, product MSB first
    assign trial = {r_rem, r_prod[shd_pkg::PROD_W-1]};
    assign diff  = trial - r_div;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == shd_pkg::CNT_W'(shd_pkg::PROD_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_ctl.ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    r_mix <= i_mix;
                    r_div <= DW'(eff_div);
                end
            end
            ST_MUL: begin
                r_prod <= shd_pkg::PROD_W'(r_mix) * shd_pkg::PROD_W'(shd_pkg::GOLDEN_MULT);
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            ST_DIV: begin
                r_prod <= r_prod << 1;
                r_cnt  <= r_cnt + shd_pkg::CNT_W'(1);
                if (trial >= r_div) begin
                    r_rem <= diff[BUCKET_BITS-1:0];
                end else begin
                    r_rem <= trial[BUCKET_BITS-1:0];
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);
    assign o_rem       = r_rem;

`ifndef ASSERT_OFF
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (DW'(r_rem) < r_div))
        else $error("remainder not below divisor");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_ctl.ack) |=> (r_state == ST_DONE))
        else $error("result dropped before ack");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL || r_state == ST_DIV) |-> (r_div != '0))
        else $error("zero divisor");
`endif

endmodule

FILE: src/string_hash_bucket_index_unit.sv
// String hash bucket index unit.
// Input channel (i_in_valid / o_in_ready): one key byte per beat, with
// i_is_last marking the final byte of a key. Bytes that are not last are
// folded into the 8-bit mix, so they stream at one per cycle while the unit is idle.
// On the last byte the mix is handed to an iterative unit: a multiply state
// multiplies it by 40503, then a restoring divider takes one product bit per
// cycle, all 24 of them. The bucket index beat reaches the output channel
// (o_out_valid / i_out_ready) from the unit's done state through an output
// register; the input is not ready while the divider runs or holds a result.
// A finished index waits in an output register, so the next key's bytes
// are taken while the receiver stalls; a second index waits in the divider
// until the output register frees.
// i_cfg_we writes the bucket count; write only while the block is idle.
// Reset (synchronous, active low) clears the mix, empties the channels and
// sets the bucket count to 1024.
module string_hash_bucket_index_unit #(
    parameter int BUCKET_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [shd_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [shd_pkg::MIX_W-1:0]       i_key_byte,
    input  logic                            i_is_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [shd_pkg::IDX_W-1:0]       o_bucket_index
);

    localparam int EW = BUCKET_BITS + shd_pkg::IDX_W;

    logic [shd_pkg::CFG_W-1:0]  r_bucket_count;
    logic [shd_pkg::MIX_W-1:0]  r_mix;
    logic                       r_out_valid;
    logic [shd_pkg::IDX_W-1:0]  r_out_idx;

    logic [shd_pkg::MIX_W-1:0]  mixed;
    logic                       in_beat;
    shd_pkg::t_mod_ctl          ctl;
    shd_pkg::t_mod_stat         stat;
    logic [BUCKET_BITS-1:0]     rem;
    logic [EW-1:0]              rem_ext;

    assign mixed      = {r_mix[shd_pkg::MIX_W-2:0], r_mix[shd_pkg::MIX_W-1]} ^ i_key_byte;
    assign o_in_ready = stat.idle;
    assign in_beat    = i_in_valid && o_in_ready;

    assign ctl.start = in_beat && i_is_last;
    assign ctl.ack   = stat.done && (!r_out_valid || i_out_ready);

    shd_mod_unit #(
        .BUCKET_BITS (BUCKET_BITS)
    ) u_mod (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_mix          (mixed),
        .i_bucket_count (r_bucket_count),
        .o_stat         (stat),
        .o_rem          (rem)
    );

    assign rem_ext = EW'(rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= shd_pkg::BUCKET_COUNT_RST;
            r_mix          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bucket_count <= i_cfg_data;
            end
            if (in_beat) begin
                r_mix <= i_is_last ? '0 : mixed;
            end
            if (ctl.ack) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ack) begin
            r_out_idx <= rem_ext[shd_pkg::IDX_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bucket_index = r_out_idx;

`ifndef ASSERT_OFF
    a_mix_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_is_last) |=> (r_mix == '0))
        else $error("mix not cleared after key");

    a_ack_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ack |=> o_out_valid)
        else $error("finished index not presented");
`endif

endmodule
